/* rtl/core/ila_pkg.sv */
// ----------------------------------------------------------------------------
// ila_pkg
// Shared types and codes for the indexed list: command and status codes,
// transfer payloads, controller states and controller/datapath interfaces.
// ----------------------------------------------------------------------------
`default_nettype none

package ila_pkg;

    localparam int CMD_W    = 3;
    localparam int POS_W    = 8;
    localparam int WORD_W   = 32;
    localparam int COUNT_W  = 9;
    localparam int STATUS_W = 2;

    // command codes; the remaining codes are accepted and do nothing
    localparam logic [CMD_W-1:0] OP_APPEND  = 3'd0;
    localparam logic [CMD_W-1:0] OP_GET     = 3'd1;
    localparam logic [CMD_W-1:0] OP_INSERT  = 3'd2;
    localparam logic [CMD_W-1:0] OP_REPLACE = 3'd3;
    localparam logic [CMD_W-1:0] OP_REMOVE  = 3'd4;

    localparam logic [STATUS_W-1:0] STS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STS_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] STS_FULL  = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0]         cmd;
        logic [POS_W-1:0]         position;
        logic signed [WORD_W-1:0] word_in;
    } in_item_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] word_out;
        logic [COUNT_W-1:0]       count;
        logic [STATUS_W-1:0]      status;
    } out_item_t;

    // how the controller has to sequence an accepted command
    typedef enum logic [1:0] {
        ACT_QUICK,
        ACT_GET,
        ACT_INSERT,
        ACT_REMOVE
    } act_e;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GET,
        ST_SHIFT,
        ST_DRAIN,
        ST_FILL,
        ST_HOLD
    } state_e;

    typedef enum logic [1:0] {
        OSRC_DEC,
        OSRC_GET,
        OSRC_RES
    } out_src_e;

    typedef struct packed {
        logic     accept;
        logic     rd_pos;
        logic     shift_step;
        logic     fill;
        logic     cap_rd;
        logic     out_load;
        out_src_e out_src;
    } ctl_t;

    typedef struct packed {
        act_e act;
        logic out_free;
        logic shift_last;
        logic shift_ins;
    } sts_t;

endpackage

`default_nettype wire

/* rtl/core/indexed_list_insert_remove.sv */
// ----------------------------------------------------------------------------
// indexed_list_insert_remove
// Fixed-capacity ordered list of signed 32-bit words with append, get,
// insert, replace and remove commands, one result per command.
// ----------------------------------------------------------------------------
// The list lives in a single RAM with one write and one registered read port,
// so one command is worked on at a time. Append, replace, rejected commands
// and removal of the last element are settled at accept; get also waits for
// its RAM read. Insert and remove at index p shift the tail of the list,
// every moved element being read and written back through the RAM ports,
// one per cycle. A finished result sits in the output register and the next
// command is accepted while it waits to be taken. No clearing pass is needed
// after reset: the fill count alone marks which entries are valid.
`default_nettype none

module indexed_list_insert_remove #(
    parameter int DEPTH = 256
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire ila_pkg::in_item_t s_item,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output ila_pkg::out_item_t     m_item
);

    ila_pkg::ctl_t ctl;
    ila_pkg::sts_t sts;

    ila_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .ctl     (ctl)
    );

    ila_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_item  (s_item),
        .m_item  (m_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .ctl     (ctl),
        .sts     (sts)
    );

endmodule

`default_nettype wire

/* rtl/core/ila_ram.sv */
// ----------------------------------------------------------------------------
// ila_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module ila_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

/* rtl/core/ila_ctrl.sv */
// ----------------------------------------------------------------------------
// ila_ctrl
// Command sequencer: accepts commands, steps the shift loop for insert and
// remove, and hands finished results to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ila_ctrl (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire ila_pkg::sts_t sts,
    output ila_pkg::ctl_t      ctl
);

    ila_pkg::state_e state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ila_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ila_pkg::ST_IDLE: begin
                if (s_valid) begin
                    case (sts.act)
                        ila_pkg::ACT_QUICK:  state_next = sts.out_free ? ila_pkg::ST_IDLE
                                                                       : ila_pkg::ST_HOLD;
                        ila_pkg::ACT_GET:    state_next = ila_pkg::ST_GET;
                        ila_pkg::ACT_INSERT: state_next = ila_pkg::ST_SHIFT;
                        ila_pkg::ACT_REMOVE: state_next = ila_pkg::ST_SHIFT;
                        default:             state_next = ila_pkg::ST_IDLE;
                    endcase
                end
            end
            ila_pkg::ST_GET: begin
                state_next = sts.out_free ? ila_pkg::ST_IDLE : ila_pkg::ST_HOLD;
            end
            ila_pkg::ST_SHIFT: begin
                if (sts.shift_last) begin
                    state_next = ila_pkg::ST_DRAIN;
                end
            end
            ila_pkg::ST_DRAIN: begin
                if (sts.shift_ins) begin
                    state_next = ila_pkg::ST_FILL;
                end else begin
                    state_next = sts.out_free ? ila_pkg::ST_IDLE : ila_pkg::ST_HOLD;
                end
            end
            ila_pkg::ST_FILL: begin
                state_next = sts.out_free ? ila_pkg::ST_IDLE : ila_pkg::ST_HOLD;
            end
            ila_pkg::ST_HOLD: begin
                if (sts.out_free) begin
                    state_next = ila_pkg::ST_IDLE;
                end
            end
            default: state_next = ila_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        s_ready        = 1'b0;
        ctl.accept     = 1'b0;
        ctl.rd_pos     = 1'b0;
        ctl.shift_step = 1'b0;
        ctl.fill       = 1'b0;
        ctl.cap_rd     = 1'b0;
        ctl.out_load   = 1'b0;
        ctl.out_src    = ila_pkg::OSRC_RES;
        case (state_reg)
            ila_pkg::ST_IDLE: begin
                s_ready    = 1'b1;
                ctl.rd_pos = 1'b1;
                ctl.accept = s_valid;
                if (s_valid && sts.act == ila_pkg::ACT_QUICK && sts.out_free) begin
                    ctl.out_load = 1'b1;
                    ctl.out_src  = ila_pkg::OSRC_DEC;
                end
            end
            ila_pkg::ST_GET: begin
                ctl.out_load = sts.out_free;
                ctl.out_src  = ila_pkg::OSRC_GET;
                ctl.cap_rd   = !sts.out_free;
            end
            ila_pkg::ST_SHIFT: begin
                ctl.shift_step = 1'b1;
            end
            ila_pkg::ST_DRAIN: begin
                ctl.out_load = !sts.shift_ins && sts.out_free;
            end
            ila_pkg::ST_FILL: begin
                ctl.fill     = 1'b1;
                ctl.out_load = sts.out_free;
            end
            ila_pkg::ST_HOLD: begin
                ctl.out_load = sts.out_free;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

/* rtl/core/ila_dpath.sv */
// ----------------------------------------------------------------------------
// ila_dpath
// Element store, fill count, command decode, shift pointers and the output
// register of the indexed list.
// ----------------------------------------------------------------------------
`default_nettype none

module ila_dpath #(
    parameter int DEPTH = 256,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CW   = $clog2(DEPTH + 1),
    localparam int PW   = (CW > ila_pkg::POS_W) ? CW : ila_pkg::POS_W + 1
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire ila_pkg::in_item_t s_item,
    output ila_pkg::out_item_t     m_item,
    output logic                   m_valid,
    input  wire logic              m_ready,
    input  wire ila_pkg::ctl_t     ctl,
    output ila_pkg::sts_t          sts
);

    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    logic [CW-1:0]               fc_reg, fc_next;
    logic                        pend_reg;
    logic                        m_valid_reg;
    ila_pkg::out_item_t          m_item_reg;
    logic [AW-1:0]               rd_ptr_reg, last_reg, wr_addr_reg, pos_reg;
    logic                        ins_reg;
    logic [ila_pkg::WORD_W-1:0]  word_reg, res_word_reg;
    logic [ila_pkg::STATUS_W-1:0] res_status_reg;

    logic [PW-1:0]               pos_ext, fc_ext, fc_m1_ext, pos_p1_ext;
    logic                        in_range, full;
    ila_pkg::act_e               dec_act;
    logic [ila_pkg::STATUS_W-1:0] dec_status;
    logic                        dec_we, dec_inc, dec_dec;
    logic [AW-1:0]               dec_waddr, pos_a, fc_a;

    logic                        ram_we;
    logic [AW-1:0]               ram_waddr, ram_raddr;
    logic [ila_pkg::WORD_W-1:0]  ram_wdata, ram_rdata;

    assign pos_ext    = PW'(s_item.position);
    assign fc_ext     = PW'(fc_reg);
    assign fc_m1_ext  = fc_ext - PW'(1);
    assign pos_p1_ext = pos_ext + PW'(1);
    assign pos_a      = pos_ext[AW-1:0];
    assign fc_a       = fc_ext[AW-1:0];
    // fc_reg never exceeds DEPTH, so this also keeps the index inside the store
    assign in_range   = pos_ext < fc_ext;
    assign full       = fc_reg == FULL_COUNT;

    // command decode against the current fill count
    always_comb begin
        dec_act    = ila_pkg::ACT_QUICK;
        dec_status = ila_pkg::STS_OK;
        dec_we     = 1'b0;
        dec_inc    = 1'b0;
        dec_dec    = 1'b0;
        dec_waddr  = pos_a;
        case (s_item.cmd)
            ila_pkg::OP_APPEND: begin
                dec_waddr = fc_a;
                if (full) begin
                    dec_status = ila_pkg::STS_FULL;
                end else begin
                    dec_we  = 1'b1;
                    dec_inc = 1'b1;
                end
            end
            ila_pkg::OP_GET: begin
                if (!in_range) begin
                    dec_status = ila_pkg::STS_RANGE;
                end else begin
                    dec_act = ila_pkg::ACT_GET;
                end
            end
            ila_pkg::OP_INSERT: begin
                if (!in_range) begin
                    dec_status = ila_pkg::STS_RANGE;
                end else if (full) begin
                    dec_status = ila_pkg::STS_FULL;
                end else begin
                    dec_act = ila_pkg::ACT_INSERT;
                    dec_inc = 1'b1;
                end
            end
            ila_pkg::OP_REPLACE: begin
                if (!in_range) begin
                    dec_status = ila_pkg::STS_RANGE;
                end else begin
                    dec_we = 1'b1;
                end
            end
            ila_pkg::OP_REMOVE: begin
                if (!in_range) begin
                    dec_status = ila_pkg::STS_RANGE;
                end else begin
                    dec_dec = 1'b1;
                    // removing the last element needs no shift
                    if (pos_ext != fc_m1_ext) begin
                        dec_act = ila_pkg::ACT_REMOVE;
                    end
                end
            end
            default: begin
                dec_act = ila_pkg::ACT_QUICK;
            end
        endcase
    end

    always_comb begin
        fc_next = fc_reg;
        if (ctl.accept && dec_inc) begin
            fc_next = fc_reg + CW'(1);
        end else if (ctl.accept && dec_dec) begin
            fc_next = fc_reg - CW'(1);
        end
    end

    // write port: quick writes at accept, shifted words in the cycle after their
    // read, and the inserted word last
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = wr_addr_reg;
        ram_wdata = ram_rdata;
        if (ctl.accept && dec_we) begin
            ram_we    = 1'b1;
            ram_waddr = dec_waddr;
            ram_wdata = s_item.word_in;
        end else if (pend_reg) begin
            ram_we = 1'b1;
        end else if (ctl.fill) begin
            ram_we    = 1'b1;
            ram_waddr = pos_reg;
            ram_wdata = word_reg;
        end
    end

    assign ram_raddr = ctl.rd_pos ? pos_a : rd_ptr_reg;

    ila_ram #(
        .WIDTH (ila_pkg::WORD_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fc_reg      <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            fc_reg   <= fc_next;
            pend_reg <= ctl.shift_step;
            if (ctl.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.accept) begin
            pos_reg        <= pos_a;
            word_reg       <= s_item.word_in;
            ins_reg        <= s_item.cmd == ila_pkg::OP_INSERT;
            res_word_reg   <= '0;
            res_status_reg <= dec_status;
            // insert walks down from the top, remove walks up from pos + 1
            if (s_item.cmd == ila_pkg::OP_INSERT) begin
                rd_ptr_reg <= fc_m1_ext[AW-1:0];
                last_reg   <= pos_a;
            end else begin
                rd_ptr_reg <= pos_p1_ext[AW-1:0];
                last_reg   <= fc_m1_ext[AW-1:0];
            end
        end
        if (ctl.shift_step) begin
            if (ins_reg) begin
                rd_ptr_reg  <= rd_ptr_reg - AW'(1);
                wr_addr_reg <= rd_ptr_reg + AW'(1);
            end else begin
                rd_ptr_reg  <= rd_ptr_reg + AW'(1);
                wr_addr_reg <= rd_ptr_reg - AW'(1);
            end
        end
        if (ctl.cap_rd) begin
            res_word_reg <= ram_rdata;
        end
        if (ctl.out_load) begin
            m_item_reg.count <= ila_pkg::COUNT_W'(fc_next);
            case (ctl.out_src)
                ila_pkg::OSRC_DEC: begin
                    m_item_reg.word_out <= '0;
                    m_item_reg.status   <= dec_status;
                end
                ila_pkg::OSRC_GET: begin
                    m_item_reg.word_out <= ram_rdata;
                    m_item_reg.status   <= ila_pkg::STS_OK;
                end
                ila_pkg::OSRC_RES: begin
                    m_item_reg.word_out <= res_word_reg;
                    m_item_reg.status   <= res_status_reg;
                end
                default: begin
                    m_item_reg.word_out <= res_word_reg;
                    m_item_reg.status   <= res_status_reg;
                end
            endcase
        end
    end

    assign m_item         = m_item_reg;
    assign m_valid        = m_valid_reg;
    assign sts.act        = dec_act;
    assign sts.out_free   = !m_valid_reg || m_ready;
    assign sts.shift_last = rd_ptr_reg == last_reg;
    assign sts.shift_ins  = ins_reg;

endmodule

`default_nettype wire
